FILE: rtl/utf8_byte_stream_decoder_core_assert.svh
// Assertion macros for the UTF-8 decoder core.
// Expects clk and rst in the scope where a macro is used.
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_ASSERT_SVH

// Checked on every edge outside reset.
`define U8D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies.
package u8dec_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00fffd;
  localparam logic [CP_W-1:0] MASK_11     = 21'h0007ff;
  localparam logic [CP_W-1:0] MASK_16     = 21'h00ffff;
  localparam logic [CP_W-1:0] MASK_21     = 21'h1fffff;
  localparam logic [7:0]      CONT_MASK   = 8'hc0;
  localparam logic [7:0]      CONT_CODE   = 8'h80;
  localparam logic [5:0]      PAYLOAD_6   = 6'h3f;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_REPL  = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_TWO   = 2'd0,
    SEQ_THREE = 2'd1,
    SEQ_FOUR  = 2'd2,
    SEQ_BAD   = 2'd3
  } seq_class_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    kind_t           kind;
    logic            last;
  } out_item_t;

endpackage

FILE: rtl/utf8_byte_stream_decoder_core.sv
// UTF-8 byte stream decoder core: sequence state, decode logic, result queue.
// Depends on u8dec_pkg and utf8_byte_stream_decoder_core_assert.svh.
//
// Takes one byte (or an end mark) per cycle while in_ready is high and turns
// it into zero, one or two code point results, which are written into a
// four-entry result queue when the item is accepted; the output is offered
// from the head of that registered queue. in_ready is high while the queue has
// at least two free entries, so with an output that takes one result per
// cycle the block sustains one item per clock. An item that interrupts a
// sequence and is itself a character yields two results; the queue absorbs
// that, and input stalls only when the output side falls behind.
`include "utf8_byte_stream_decoder_core_assert.svh"

module utf8_byte_stream_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u8dec_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8dec_pkg::out_item_t out_item
);
  import u8dec_pkg::*;

  // sequence state
  logic [1:0]      bytes_remaining, bytes_remaining_next;
  seq_class_t      seq_class, seq_class_next;
  logic [CP_W-1:0] accumulator, accumulator_next;

  // result queue
  out_item_t         queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;

  logic      accept, pop;
  logic [1:0] n_push;
  out_item_t res0, res1;

  // idle-path decode of the current byte
  logic            st_emit;
  logic [CP_W-1:0] st_cp;
  kind_t           st_kind;
  logic            st_lead;
  seq_class_t      st_class;
  logic [1:0]      st_rem;

  logic [7:0]      b;
  logic            is_cont;
  logic [CP_W-1:0] acc_shift;

  assign b         = in_item.in_byte;
  assign is_cont   = (b & CONT_MASK) == CONT_CODE;
  assign acc_shift = {accumulator[CP_W-7:0], b[5:0] & PAYLOAD_6};

  always_comb begin
    st_emit  = 1'b0;
    st_cp    = REPLACEMENT;
    st_kind  = KIND_REPL;
    st_lead  = 1'b0;
    st_class = SEQ_TWO;
    st_rem   = 2'd0;
    if (!b[7]) begin
      st_emit = 1'b1;
      st_cp   = {{(CP_W-8){1'b0}}, b};
      st_kind = KIND_CHAR;
    end else if (!b[6]) begin
      st_emit = 1'b1;  // stray continuation byte
    end else begin
      st_lead = 1'b1;
      if (!b[5]) begin
        st_class = SEQ_TWO;
        st_rem   = 2'd1;
      end else if (!b[4]) begin
        st_class = SEQ_THREE;
        st_rem   = 2'd2;
      end else if (!b[3]) begin
        st_class = SEQ_FOUR;
        st_rem   = 2'd3;
      end else begin
        st_class = SEQ_BAD;
        st_rem   = 2'd3;
      end
    end
  end

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    seq_class_next       = seq_class;
    accumulator_next     = accumulator;
    n_push               = 2'd0;
    res0                 = '{code_point: REPLACEMENT, kind: KIND_REPL, last: 1'b1};
    res1                 = '{code_point: st_cp, kind: st_kind, last: 1'b1};
    if (in_item.end_of_input) begin
      if (bytes_remaining != 2'd0) begin
        n_push               = 2'd1;
        res0                 = '{code_point: '0, kind: KIND_TRUNC, last: 1'b1};
        bytes_remaining_next = 2'd0;
      end
    end else if (bytes_remaining == 2'd0 || !is_cont) begin
      // idle or interrupted sequence: an interrupted one gives a replacement first, then the byte as a new start
      if (bytes_remaining != 2'd0) begin
        n_push = 2'd1;
        if (st_emit) begin
          n_push    = 2'd2;
          res0.last = 1'b0;
        end
      end else if (st_emit) begin
        n_push = 2'd1;
        res0   = '{code_point: st_cp, kind: st_kind, last: 1'b1};
      end
      bytes_remaining_next = st_lead ? st_rem : 2'd0;
      if (st_lead) begin
        seq_class_next   = st_class;
        accumulator_next = {{(CP_W-6){1'b0}}, b[5:0] & PAYLOAD_6};
      end
    end else begin
      accumulator_next     = acc_shift;
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        n_push = 2'd1;
        case (seq_class)
          SEQ_TWO:   res0 = '{code_point: acc_shift & MASK_11, kind: KIND_CHAR, last: 1'b1};
          SEQ_THREE: res0 = '{code_point: acc_shift & MASK_16, kind: KIND_CHAR, last: 1'b1};
          SEQ_FOUR:  res0 = '{code_point: acc_shift & MASK_21, kind: KIND_CHAR, last: 1'b1};
          default:   res0 = '{code_point: REPLACEMENT, kind: KIND_REPL, last: 1'b1};
        endcase
      end
    end
  end

  assign in_ready  = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign accept    = in_valid && in_ready;
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_item  = queue[rd_ptr];

  always_comb begin
    count_next = count - QCNT_W'(pop);
    if (accept) begin
      count_next = count_next + QCNT_W'(n_push);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      seq_class       <= SEQ_TWO;
      accumulator     <= '0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (accept) begin
        bytes_remaining <= bytes_remaining_next;
        seq_class       <= seq_class_next;
        accumulator     <= accumulator_next;
        wr_ptr          <= wr_ptr + QPTR_W'(n_push);
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
      if (n_push == 2'd2) begin
        queue[wr_ptr + QPTR_W'(1)] <= res1;
      end
    end
  end

  // count is unknown until the first reset edge, so reset itself satisfies the bound
  `U8D_ASSERT_ALWAYS(a_count_bound, rst || count <= QCNT_W'(QUEUE_DEPTH), "result queue overflow")
  `U8D_ASSERT(a_end_goes_idle, accept && in_item.end_of_input |=> bytes_remaining == 2'd0,
    "sequence still open after end mark")
  `U8D_ASSERT(a_ascii_one_result,
    accept && !in_item.end_of_input && bytes_remaining == 2'd0 && !in_item.in_byte[7]
      |=> count == $past(count) + QCNT_W'(1) - QCNT_W'($past(pop)),
    "plain character did not yield exactly one result")
  `U8D_ASSERT(a_queue_pointers,
    ((QPTR_W'(count) + rd_ptr) == wr_ptr),
    "queue pointers disagree with fill count")

endmodule

FILE: tb/tb.sv
// Testbench for utf8_byte_stream_decoder_core: directed and random byte streams
// checked against an in-bench decoder model. Depends on u8dec_pkg and the core.
module tb;
  import u8dec_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // decoder model state
  logic [1:0]      dec_left  = '0;
  seq_class_t      dec_class = SEQ_TWO;
  logic [CP_W-1:0] dec_acc   = '0;
  out_item_t       expected_cps[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  bit no_gaps      = 1'b0;
  bit no_stalls    = 1'b0;

  utf8_byte_stream_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t mk_result(logic [CP_W-1:0] cp, kind_t k);
    out_item_t r;
    r.code_point = cp;
    r.kind       = k;
    r.last       = 1'b0;
    return r;
  endfunction

  // Byte seen while idle; returns 1 when it yields a result on its own.
  function automatic bit start_seq(logic [7:0] b, output out_item_t r);
    r = mk_result('0, KIND_CHAR);
    if (b < 8'h80) begin
      r = mk_result({13'd0, b}, KIND_CHAR);
      return 1'b1;
    end
    if (b < 8'hc0) begin
      r = mk_result(REPLACEMENT, KIND_REPL);
      return 1'b1;
    end
    dec_acc = {15'd0, b[5:0]};
    if (!b[5]) begin
      dec_class = SEQ_TWO;
      dec_left  = 2'd1;
    end else if (!b[4]) begin
      dec_class = SEQ_THREE;
      dec_left  = 2'd2;
    end else if (!b[3]) begin
      dec_class = SEQ_FOUR;
      dec_left  = 2'd3;
    end else begin
      dec_class = SEQ_BAD;
      dec_left  = 2'd3;
    end
    return 1'b0;
  endfunction

  task automatic decode_item(input in_item_t it);
    out_item_t  res[$];
    out_item_t  r;
    logic [7:0] b;
    b = it.in_byte;
    if (it.end_of_input) begin
      if (dec_left != 0) begin
        res.push_back(mk_result('0, KIND_TRUNC));
        dec_left = '0;
      end
    end else if (dec_left == 0) begin
      if (start_seq(b, r)) res.push_back(r);
    end else if ((b & CONT_MASK) != CONT_CODE) begin
      // interrupted sequence: replacement, then the byte starts over
      res.push_back(mk_result(REPLACEMENT, KIND_REPL));
      dec_left = '0;
      if (start_seq(b, r)) res.push_back(r);
    end else begin
      dec_acc  = {dec_acc[CP_W-7:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 0) begin
        case (dec_class)
          SEQ_TWO:   res.push_back(mk_result(dec_acc & MASK_11, KIND_CHAR));
          SEQ_THREE: res.push_back(mk_result(dec_acc & MASK_16, KIND_CHAR));
          SEQ_FOUR:  res.push_back(mk_result(dec_acc & MASK_21, KIND_CHAR));
          default:   res.push_back(mk_result(REPLACEMENT, KIND_REPL));
        endcase
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_cps.push_back(res[i]);
  endtask

  // Accepted items feed the model first, so a result can never outrun it.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) decode_item(in_item);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_cps.size() == 0) begin
          errors++;
          $error("unexpected result: code_point %h kind %0d last %0d",
                 out_item.code_point, out_item.kind, out_item.last);
        end else begin
          want = expected_cps.pop_front();
          if (out_item.code_point !== want.code_point) begin
            errors++;
            $error("code_point: expected %h, got %h", want.code_point, out_item.code_point);
          end
          if (out_item.kind !== want.kind) begin
            errors++;
            $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          end
          if (out_item.last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, out_item.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= no_stalls || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Valid is only lowered when a gap follows, never in the step it is raised.
  task automatic send_item(input in_item_t it);
    if (!no_gaps && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!it.end_of_input) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.in_byte      = b;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it.in_byte      = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  function automatic logic [7:0] rand_cont();
    return CONT_CODE | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_lead(seq_class_t c);
    case (c)
      SEQ_TWO:   return 8'hc0 | 8'($urandom_range(0, 31));
      SEQ_THREE: return 8'he0 | 8'($urandom_range(0, 15));
      SEQ_FOUR:  return 8'hf0 | 8'($urandom_range(0, 7));
      default:   return 8'hf8 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic int cont_count(seq_class_t c);
    return (c == SEQ_TWO) ? 1 : (c == SEQ_THREE) ? 2 : 3;
  endfunction

  // any byte that is not a continuation
  function automatic logic [7:0] rand_non_cont();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b & CONT_MASK) == CONT_CODE) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'hbf);   // stray continuation
  endtask

  task automatic test_sequences();
    send_byte(8'hc0); send_byte(8'h80);
    send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);
    send_byte(8'hf7); send_byte(8'hbf); send_byte(8'hbf); send_byte(8'hbf);
    // F8-FF lead runs its course, then gives a replacement
    send_byte(8'hff); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
  endtask

  task automatic test_end_marks();
    send_byte(8'he5);
    send_byte(8'h80);
    send_end();         // truncation
    send_end();         // idle now, nothing comes out
  endtask

  task automatic test_interrupts();
    send_byte(8'hc3); send_byte(8'h41);                     // two results on one item
    send_byte(8'he2); send_byte(8'hc3); send_byte(8'ha9);   // new lead restarts
  endtask

  task automatic test_random_stream();
    int         start;
    int         pick;
    int         n;
    seq_class_t c;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // one stretch of full rate on both sides
      no_gaps   = (items_sent - start >= 500) && (items_sent - start < 650);
      no_stalls = no_gaps;
      pick = $urandom_range(0, 99);
      c    = seq_class_t'($urandom_range(0, 3));
      if (pick < 20) begin
        send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 72) begin
        if (pick < 35)      c = SEQ_TWO;
        else if (pick < 50) c = SEQ_THREE;
        else if (pick < 65) c = SEQ_FOUR;
        else                c = SEQ_BAD;
        send_byte(rand_lead(c));
        repeat (cont_count(c)) send_byte(rand_cont());
      end else if (pick < 80) begin
        send_byte(rand_cont());
      end else if (pick < 88) begin
        n = $urandom_range(0, cont_count(c) - 1);
        send_byte(rand_lead(c));
        repeat (n) send_byte(rand_cont());
        send_byte(rand_non_cont());
      end else if (pick < 94) begin
        n = $urandom_range(0, cont_count(c) - 1);
        send_byte(rand_lead(c));
        repeat (n) send_byte(rand_cont());
        send_end();
        if ($urandom_range(0, 1)) send_end();
      end else if (pick < 97) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_end();
      end
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_sequences();
    test_end_marks();
    test_interrupts();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d bytes sent (ASCII, 2/3/4-byte, F8-FF leads, strays, cut-offs)",
             items_sent);
    $display("tb: %0d code point results compared", results_seen);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: utf8_byte_stream_decoder_core.f
+incdir+rtl
rtl/u8dec_pkg.sv
rtl/utf8_byte_stream_decoder_core.sv
tb/tb.sv
